[hw/rtl/swtr_pkg.sv]
// Package for the single-wire temperature reader: timer width, register
// indexes, phase encoding, configuration and state structs, helper functions.
// No dependencies.
package swtr_pkg;

  localparam int TIMER_BITS = 18;
  localparam logic [31:0] TIMER_MAX = 32'((64'd1 << TIMER_BITS) - 64'd1);

  typedef logic [TIMER_BITS-1:0] timer_t;

  // Configuration register indexes.
  localparam logic [2:0] REG_RESET_LOW    = 3'd0;
  localparam logic [2:0] REG_CONVERT_WAIT = 3'd1;
  localparam logic [2:0] REG_SLOT_LOW     = 3'd2;
  localparam logic [2:0] REG_SAMPLE_DELAY = 3'd3;
  localparam logic [2:0] REG_RECOVERY     = 3'd4;
  localparam logic [2:0] REG_FIELD_GAP    = 3'd5;

  // Input kinds carried on tuser.
  localparam logic KIND_TICK  = 1'b0;
  localparam logic KIND_START = 1'b1;

  // Fields read after the reset pulse.
  localparam logic [2:0] FLD_STATUS0 = 3'd0;
  localparam logic [2:0] FLD_STATUS1 = 3'd1;
  localparam logic [2:0] FLD_SIGN    = 3'd2;
  localparam logic [2:0] FLD_BYTE_HI = 3'd3;
  localparam logic [2:0] FLD_BYTE_LO = 3'd4;

  typedef enum logic [6:0] {
    PH_IDLE     = 7'b0000001,
    PH_RESET    = 7'b0000010,
    PH_CONV     = 7'b0000100,
    PH_SLOT_LOW = 7'b0001000,
    PH_SAMPLE   = 7'b0010000,
    PH_RECOVER  = 7'b0100000,
    PH_GAP      = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic [9:0]  reset_low_us;
    logic [17:0] convert_wait_us;
    logic [7:0]  slot_low_us;
    logic [7:0]  sample_delay_us;
    logic [7:0]  recovery_us;
    logic [7:0]  field_gap_us;
  } cfg_t;

  typedef struct packed {
    phase_t      phase;
    timer_t      wait_timer;
    logic [3:0]  bits_left;
    logic [2:0]  field_index;
    logic [15:0] shift_value;
    logic        sign_bit;
    logic [1:0]  status_store;
    logic [16:0] temperature_store;
  } state_t;

  typedef struct packed {
    logic drive_low;
    logic busy;
    logic done;
  } flags_t;

  // Load value for the phase timer: zero counts as one tick, long values
  // saturate at the timer's range.
  function automatic timer_t phase_ticks(input logic [17:0] dur);
    logic [31:0] wide;
    wide = {14'd0, dur};
    if (wide == 32'd0) begin
      wide = 32'd1;
    end else if (wide > TIMER_MAX) begin
      wide = TIMER_MAX;
    end
    return TIMER_BITS'(wide);
  endfunction

endpackage

[hw/rtl/single_wire_temperature_reader_core.sv]
// Single-wire temperature reader: top level with configuration registers,
// sequencer state and the output register. Depends on swtr_pkg and swtr_step.
//
// Usage: every transfer on the slave stream is either a one-microsecond tick
// (tuser = 0, tdata[0] = sampled data line level) or a start request
// (tuser = 1). A start while a reading is under way is ignored. Each
// accepted transfer yields exactly one transfer on the master stream with
// the line drive for the following ticks, busy and done flags, and the
// status and temperature of the last completed reading (1/256 degree).
// The result is registered: it is in the output register in the cycle after
// the input transfer. Throughput is one transfer per cycle while the master
// side takes results, set by the single register stage of the sequencer state.
// When the master side stalls, the held result blocks new input only while
// the output register is full and not being taken; no transfer is dropped.
// Reset (rst, synchronous) idles the sequencer, clears both result stores,
// empties the output register and loads the default timings (500 us reset
// pulse, 150 ms conversion wait, 10/20/30 us slot timing, 10 us field gap).
// Configuration writes take effect on the edge where cfg_we is high.
module single_wire_temperature_reader_core import swtr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [0] line_level, [7:1] zero
  input  logic [0:0]  s_tuser,   // [0] kind
  output logic        m_tvalid,
  input  logic        m_tready,
  // [0] drive_low, [1] busy_res, [2] done_res, [3] reading_ok,
  // [5:4] status_bits, [22:6] temperature, [23] zero
  output logic [23:0] m_tdata,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [17:0] cfg_wdata
);

  cfg_t   cfg;
  state_t st;
  state_t st_next;
  flags_t flags;
  logic   in_xfer;

  assign s_tready = !m_tvalid || m_tready;
  assign in_xfer  = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.reset_low_us    <= 10'd500;
      cfg.convert_wait_us <= 18'd150000;
      cfg.slot_low_us     <= 8'd10;
      cfg.sample_delay_us <= 8'd20;
      cfg.recovery_us     <= 8'd30;
      cfg.field_gap_us    <= 8'd10;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_RESET_LOW:    cfg.reset_low_us    <= cfg_wdata[9:0];
        REG_CONVERT_WAIT: cfg.convert_wait_us <= cfg_wdata;
        REG_SLOT_LOW:     cfg.slot_low_us     <= cfg_wdata[7:0];
        REG_SAMPLE_DELAY: cfg.sample_delay_us <= cfg_wdata[7:0];
        REG_RECOVERY:     cfg.recovery_us     <= cfg_wdata[7:0];
        REG_FIELD_GAP:    cfg.field_gap_us    <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  swtr_step u_step (
    .st         (st),
    .cfg        (cfg),
    .kind       (s_tuser[0]),
    .line_level (s_tdata[0]),
    .st_next    (st_next),
    .flags      (flags)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase             <= PH_IDLE;
      st.wait_timer        <= '0;
      st.bits_left         <= 4'd0;
      st.field_index       <= FLD_STATUS0;
      st.shift_value       <= '0;
      st.sign_bit          <= 1'b0;
      st.status_store      <= 2'b00;
      st.temperature_store <= '0;
    end else if (in_xfer) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_xfer) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      m_tdata <= {1'b0, st_next.temperature_store, st_next.status_store,
                  (st_next.status_store == 2'b00), flags.done, flags.busy,
                  flags.drive_low};
    end
  end

`ifndef NO_ASSERTIONS
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[2] && m_tdata[1]))
    else $error("done reported while still busy");

  a_drive_needs_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> m_tdata[1])
    else $error("line driven low outside a reading");

  a_idle_timer_clear: assert property (@(posedge clk) disable iff (rst)
    st.phase == PH_IDLE |-> st.wait_timer == '0)
    else $error("timer running while idle");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> m_tvalid)
    else $error("accepted transfer produced no result");

  a_stall_holds_state: assert property (@(posedge clk) disable iff (rst)
    !in_xfer && !$past(rst) |=> $stable(st))
    else $error("sequencer state changed without a transfer");
`endif

endmodule

[hw/rtl/swtr_step.sv]
// Next-state logic of the reader sequencer for one tick or start transfer.
// Depends on swtr_pkg.
module swtr_step import swtr_pkg::*; (
  input  state_t st,
  input  cfg_t   cfg,
  input  logic   kind,
  input  logic   line_level,
  output state_t st_next,
  output flags_t flags
);

  logic field_end;
  logic done;

  always_comb begin
    st_next   = st;
    field_end = 1'b0;
    done      = 1'b0;

    if (kind == KIND_START) begin
      if (st.phase == PH_IDLE) begin
        st_next.sign_bit    = 1'b0;
        st_next.shift_value = '0;
        st_next.field_index = FLD_STATUS0;
        st_next.bits_left   = 4'd0;
        st_next.phase       = PH_RESET;
        st_next.wait_timer  = phase_ticks({8'd0, cfg.reset_low_us});
      end
    end else if (st.phase != PH_IDLE) begin
      if (st.wait_timer > timer_t'(1)) begin
        st_next.wait_timer = st.wait_timer - timer_t'(1);
      end else begin
        st_next.wait_timer = '0;
        case (st.phase)
          PH_RESET: begin
            st_next.field_index = FLD_STATUS0;
            st_next.bits_left   = 4'd1;
            st_next.shift_value = '0;
            st_next.phase       = PH_CONV;
            st_next.wait_timer  = phase_ticks(cfg.convert_wait_us);
          end
          PH_CONV: begin
            st_next.phase      = PH_SLOT_LOW;
            st_next.wait_timer = phase_ticks({10'd0, cfg.slot_low_us});
          end
          PH_SLOT_LOW: begin
            st_next.phase      = PH_SAMPLE;
            st_next.wait_timer = phase_ticks({10'd0, cfg.sample_delay_us});
          end
          PH_SAMPLE: begin
            st_next.shift_value = {st.shift_value[14:0], line_level};
            if (st.bits_left != 4'd0) begin
              st_next.bits_left = st.bits_left - 4'd1;
            end
            st_next.phase      = PH_RECOVER;
            st_next.wait_timer = phase_ticks({10'd0, cfg.recovery_us});
          end
          PH_RECOVER: begin
            if (st.bits_left != 4'd0) begin
              st_next.phase      = PH_SLOT_LOW;
              st_next.wait_timer = phase_ticks({10'd0, cfg.slot_low_us});
            end else if (cfg.field_gap_us != 8'd0) begin
              st_next.phase      = PH_GAP;
              st_next.wait_timer = phase_ticks({10'd0, cfg.field_gap_us});
            end else begin
              field_end = 1'b1;
            end
          end
          PH_GAP: begin
            field_end = 1'b1;
          end
          default: begin
            st_next.phase = PH_IDLE;
          end
        endcase
      end
    end

    // End of a field: start the next one or close the reading.
    if (field_end) begin
      case (st.field_index)
        FLD_STATUS0: begin
          st_next.field_index = FLD_STATUS1;
          st_next.bits_left   = 4'd1;
          st_next.phase       = PH_SLOT_LOW;
          st_next.wait_timer  = phase_ticks({10'd0, cfg.slot_low_us});
        end
        FLD_STATUS1: begin
          if (st_next.shift_value[1:0] != 2'b00) begin
            st_next.status_store      = st_next.shift_value[1:0];
            st_next.temperature_store = '0;
            st_next.phase             = PH_IDLE;
            st_next.wait_timer        = '0;
            st_next.bits_left         = 4'd0;
            done                      = 1'b1;
          end else begin
            st_next.field_index = FLD_SIGN;
            st_next.bits_left   = 4'd1;
            st_next.shift_value = '0;
            st_next.phase       = PH_SLOT_LOW;
            st_next.wait_timer  = phase_ticks({10'd0, cfg.slot_low_us});
          end
        end
        FLD_SIGN: begin
          st_next.sign_bit    = st_next.shift_value[0];
          st_next.shift_value = '0;
          st_next.field_index = FLD_BYTE_HI;
          st_next.bits_left   = 4'd8;
          st_next.phase       = PH_SLOT_LOW;
          st_next.wait_timer  = phase_ticks({10'd0, cfg.slot_low_us});
        end
        FLD_BYTE_HI: begin
          st_next.field_index = FLD_BYTE_LO;
          st_next.bits_left   = 4'd8;
          st_next.phase       = PH_SLOT_LOW;
          st_next.wait_timer  = phase_ticks({10'd0, cfg.slot_low_us});
        end
        FLD_BYTE_LO: begin
          // Subtracting 65536 in 17-bit two's complement just sets the top bit.
          st_next.status_store      = 2'b00;
          st_next.temperature_store = {st_next.sign_bit, st_next.shift_value};
          st_next.phase             = PH_IDLE;
          st_next.wait_timer        = '0;
          st_next.bits_left         = 4'd0;
          done                      = 1'b1;
        end
        default: begin
          st_next.phase      = PH_IDLE;
          st_next.wait_timer = '0;
          st_next.bits_left  = 4'd0;
          done               = 1'b1;
        end
      endcase
    end

    flags.drive_low = (st_next.phase == PH_RESET) || (st_next.phase == PH_SLOT_LOW);
    flags.busy      = (st_next.phase != PH_IDLE);
    flags.done      = done;
  end

endmodule

[dv/tb_single_wire_temperature_reader_core.sv]
// Testbench for single_wire_temperature_reader_core: a stream of tick and start
// transfers against a transfer-by-transfer prediction of the sensor read sequence.
// Depends on swtr_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb_single_wire_temperature_reader_core;
  import swtr_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int DRAIN_AT    = 900;

  typedef struct packed {
    phase_t      ph;
    timer_t      left;
    logic [3:0]  bits_left;
    logic [2:0]  fld;
    logic [15:0] shreg;
    logic        sign;
    logic [1:0]  status;
    logic [16:0] temp;
  } reader_t;

  typedef struct packed {
    logic        drive;
    logic        busy;
    logic        done;
    logic        ok;
    logic [1:0]  status;
    logic [16:0] temp;
  } readout_t;

  typedef struct packed {
    reader_t  nxt;
    readout_t res;
  } advance_t;

  typedef struct packed {
    logic kind;
    logic line;
  } wire_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;   // [0] line_level, [7:1] zero
  logic [0:0]  s_tuser = 1'b0;   // [0] kind
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // [0] drive_low, [1] busy_res, [2] done_res, [3] reading_ok,
  // [5:4] status_bits, [22:6] temperature, [23] zero
  logic [23:0] m_tdata;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_addr = REG_RESET_LOW;
  logic [17:0] cfg_wdata = 18'd0;

  cfg_t       timing;
  wire_item_t pending_items[$];
  readout_t   expected_readouts[$];
  logic [18:0] forced_plans[$];

  reader_t     gen_st;
  reader_t     model_st;
  logic [18:0] plan_bits;
  int          plan_ptr;
  bit          plan_noisy;
  int          gen_count = 0;

  int in_count = 0;
  int out_count = 0;
  int mismatch_count = 0;
  int send_idle = 0;
  int recv_idle = 0;
  int popped_count = 0;
  bit holding = 1'b0;
  int cycle_count = 0;
  advance_t stepped;
  wire_item_t next_item;

  single_wire_temperature_reader_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // A zero duration still lasts one tick; anything past the timer range saturates.
  function automatic reader_t enter_phase(reader_t s, phase_t p, logic [17:0] dur);
    logic [31:0] ticks;
    ticks = {14'd0, dur};
    if (ticks == 32'd0) begin
      ticks = 32'd1;
    end else if (ticks > TIMER_MAX) begin
      ticks = TIMER_MAX;
    end
    s.ph = p;
    s.left = timer_t'(ticks);
    return s;
  endfunction

  function automatic reader_t finish_reading(reader_t s, logic [1:0] status,
                                             logic [16:0] temp);
    s.status = status;
    s.temp = temp;
    s.ph = PH_IDLE;
    s.left = '0;
    s.bits_left = 4'd0;
    return s;
  endfunction

  // Next state and output of the reader for one tick or start transfer.
  function automatic advance_t sensor_read_next(reader_t s, cfg_t c, logic kind,
                                                logic line);
    advance_t r;
    logic done;
    logic field_over;
    done = 1'b0;
    field_over = 1'b0;
    if (kind == KIND_START) begin
      if (s.ph == PH_IDLE) begin
        s.sign = 1'b0;
        s.shreg = 16'd0;
        s.fld = FLD_STATUS0;
        s.bits_left = 4'd0;
        s = enter_phase(s, PH_RESET, c.reset_low_us);
      end
    end else if (s.ph != PH_IDLE) begin
      if (s.left > 1) begin
        s.left = s.left - 1'b1;
      end else begin
        s.left = '0;
        case (s.ph)
          PH_RESET: begin
            s.fld = FLD_STATUS0;
            s.bits_left = 4'd1;
            s.shreg = 16'd0;
            s = enter_phase(s, PH_CONV, c.convert_wait_us);
          end
          PH_CONV: s = enter_phase(s, PH_SLOT_LOW, c.slot_low_us);
          PH_SLOT_LOW: s = enter_phase(s, PH_SAMPLE, c.sample_delay_us);
          PH_SAMPLE: begin
            s.shreg = {s.shreg[14:0], line};
            if (s.bits_left != 4'd0) s.bits_left = s.bits_left - 1'b1;
            s = enter_phase(s, PH_RECOVER, c.recovery_us);
          end
          PH_RECOVER: begin
            if (s.bits_left != 4'd0) begin
              s = enter_phase(s, PH_SLOT_LOW, c.slot_low_us);
            end else if (c.field_gap_us != 8'd0) begin
              s = enter_phase(s, PH_GAP, c.field_gap_us);
            end else begin
              field_over = 1'b1;
            end
          end
          PH_GAP: field_over = 1'b1;
          default: s.ph = PH_IDLE;
        endcase
        if (field_over) begin
          case (s.fld)
            FLD_STATUS0: begin
              s.fld = FLD_STATUS1;
              s.bits_left = 4'd1;
              s = enter_phase(s, PH_SLOT_LOW, c.slot_low_us);
            end
            FLD_STATUS1: begin
              if (s.shreg[1:0] != 2'b00) begin
                s = finish_reading(s, s.shreg[1:0], 17'd0);
                done = 1'b1;
              end else begin
                s.fld = FLD_SIGN;
                s.bits_left = 4'd1;
                s.shreg = 16'd0;
                s = enter_phase(s, PH_SLOT_LOW, c.slot_low_us);
              end
            end
            FLD_SIGN: begin
              s.sign = s.shreg[0];
              s.shreg = 16'd0;
              s.fld = FLD_BYTE_HI;
              s.bits_left = 4'd8;
              s = enter_phase(s, PH_SLOT_LOW, c.slot_low_us);
            end
            FLD_BYTE_HI: begin
              s.fld = FLD_BYTE_LO;
              s.bits_left = 4'd8;
              s = enter_phase(s, PH_SLOT_LOW, c.slot_low_us);
            end
            FLD_BYTE_LO: begin
              // Subtracting 65536 from a 17-bit value is the same as setting bit 16.
              s = finish_reading(s, 2'b00, {s.sign, s.shreg});
              done = 1'b1;
            end
            default: begin
              s.ph = PH_IDLE;
              s.left = '0;
              s.bits_left = 4'd0;
              done = 1'b1;
            end
          endcase
        end
      end
    end
    r.nxt = s;
    r.res.drive = (s.ph == PH_RESET) || (s.ph == PH_SLOT_LOW);
    r.res.busy = (s.ph != PH_IDLE);
    r.res.done = done;
    r.res.ok = (s.status == 2'b00);
    r.res.status = s.status;
    r.res.temp = s.temp;
    return r;
  endfunction

  task automatic log_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("mismatch at result %0d: %s", out_count, msg);
  endtask

  task automatic check_field(input string what, input logic [16:0] want,
                             input logic [16:0] got);
    if (want !== got) log_mismatch($sformatf("%s expected %0h, got %0h", what, want, got));
  endtask

  // The generator runs its own copy of the reader so that it knows which
  // tick is sampled and can put the planned bit on the line there.
  task automatic push_item(input logic kind, input logic line);
    advance_t a;
    logic lvl;
    lvl = line;
    if (kind == KIND_TICK && gen_st.ph == PH_SAMPLE && gen_st.left <= 1 && !plan_noisy) begin
      lvl = plan_bits[plan_ptr];
      if (plan_ptr > 0) plan_ptr--;
    end
    a = sensor_read_next(gen_st, timing, kind, lvl);
    gen_st = a.nxt;
    pending_items.push_back({kind, lvl});
    gen_count++;
  endtask

  // Plan bits from the top: two status bits, the sign, then the 16-bit value.
  task automatic run_reading(input logic [18:0] plan, input bit noisy);
    plan_bits = plan;
    plan_ptr = 18;
    plan_noisy = noisy;
    push_item(KIND_START, 1'($urandom_range(1)));
    while (gen_st.ph != PH_IDLE) begin
      push_item(($urandom_range(99) < 3) ? KIND_START : KIND_TICK, 1'($urandom_range(1)));
    end
    repeat ($urandom_range(3)) push_item(KIND_TICK, 1'($urandom_range(1)));
  endtask

  task automatic random_phase(input int target);
    int stop_at;
    int pick;
    stop_at = gen_count + target;
    while (gen_count < stop_at) begin
      pick = $urandom_range(99);
      if (forced_plans.size() != 0) begin
        run_reading(forced_plans.pop_front(), 1'b0);
      end else if (pick < 10) begin
        run_reading(19'($urandom), 1'b1);
      end else if (pick < 25) begin
        run_reading({2'($urandom_range(3, 1)), 17'($urandom)}, 1'b0);
      end else begin
        run_reading({2'b00, 17'($urandom)}, 1'b0);
      end
    end
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [17:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_RESET_LOW:    timing.reset_low_us = val[9:0];
      REG_CONVERT_WAIT: timing.convert_wait_us = val;
      REG_SLOT_LOW:     timing.slot_low_us = val[7:0];
      REG_SAMPLE_DELAY: timing.sample_delay_us = val[7:0];
      REG_RECOVERY:     timing.recovery_us = val[7:0];
      REG_FIELD_GAP:    timing.field_gap_us = val[7:0];
      default: ;
    endcase
  endtask

  task automatic write_timing(input logic [17:0] r_low, input logic [17:0] r_conv,
                              input logic [17:0] r_slot, input logic [17:0] r_sample,
                              input logic [17:0] r_recov, input logic [17:0] r_gap);
    write_reg(REG_RESET_LOW, r_low);
    write_reg(REG_CONVERT_WAIT, r_conv);
    write_reg(REG_SLOT_LOW, r_slot);
    write_reg(REG_SAMPLE_DELAY, r_sample);
    write_reg(REG_RECOVERY, r_recov);
    write_reg(REG_FIELD_GAP, r_gap);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Sampled mid-cycle so that nothing races with the edge.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_items.size() != 0 || s_tvalid || in_count != out_count);
  endtask

  // Sender.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      popped_count = 0;
      holding = 1'b0;
    end else begin
      if (holding && !s_tvalid && in_count == out_count) holding = 1'b0;
      if (!s_tvalid || s_tready) begin
        if (!holding && pending_items.size() != 0 && $urandom_range(99) >= send_idle) begin
          next_item = pending_items.pop_front();
          s_tvalid <= 1'b1;
          s_tuser <= next_item.kind;
          s_tdata <= {7'd0, next_item.line};
          popped_count++;
          // Once in the run, stop sending until every result is back.
          if (popped_count == DRAIN_AT) holding = 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver.
  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(99) >= recv_idle);
  end

  // Monitor: checks each result transfer, then predicts for each input transfer.
  always @(posedge clk) begin
    if (rst) begin
      model_st = '0;
      model_st.ph = PH_IDLE;
    end else begin
      if (m_tvalid && m_tready) begin
        out_count <= out_count + 1;
        if (expected_readouts.size() == 0) begin
          log_mismatch($sformatf("result %0h with nothing expected", m_tdata));
        end else begin
          stepped.res = expected_readouts.pop_front();
          check_field("drive_low", 17'(stepped.res.drive), 17'(m_tdata[0]));
          check_field("busy_res", 17'(stepped.res.busy), 17'(m_tdata[1]));
          check_field("done_res", 17'(stepped.res.done), 17'(m_tdata[2]));
          check_field("reading_ok", 17'(stepped.res.ok), 17'(m_tdata[3]));
          check_field("status_bits", 17'(stepped.res.status), 17'(m_tdata[5:4]));
          check_field("temperature", stepped.res.temp, m_tdata[22:6]);
        end
      end
      if (s_tvalid && s_tready) begin
        stepped = sensor_read_next(model_st, timing, s_tuser[0], s_tdata[0]);
        model_st = stepped.nxt;
        expected_readouts.push_back(stepped.res);
        in_count <= in_count + 1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_single_wire_temperature_reader_core NOT OK");
      $finish;
    end
  end

  initial begin
    timing = '{10'd500, 18'd150000, 8'd10, 8'd20, 8'd30, 8'd10};
    gen_st = '0;
    gen_st.ph = PH_IDLE;
    forced_plans = '{{2'b00, 1'b0, 16'h0000}, {2'b00, 1'b0, 16'hFFFF},
                     {2'b00, 1'b1, 16'h0000}, {2'b00, 1'b1, 16'hFFFF},
                     {2'b01, 17'h1FFFF}, {2'b11, 17'h0}};
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    send_idle = 29;
    recv_idle = 48;

    // Ticks before any reading leave the idle defaults in place.
    push_item(KIND_TICK, 1'b0);
    push_item(KIND_TICK, 1'b1);
    wait_drained();

    // All durations zero, no field gap, a start while busy and a bad status.
    write_timing(18'd0, 18'd0, 18'd0, 18'd0, 18'd0, 18'd0);
    plan_bits = {2'b10, 17'd0};
    plan_ptr = 18;
    plan_noisy = 1'b0;
    push_item(KIND_START, 1'b1);
    push_item(KIND_START, 1'b0);
    while (gen_st.ph != PH_IDLE) push_item(KIND_TICK, 1'b1);
    push_item(KIND_TICK, 1'b0);
    wait_drained();

    write_timing(18'd1, 18'd1, 18'd1, 18'd1, 18'd1, 18'd0);
    random_phase(200);
    wait_drained();

    write_timing(18'($urandom_range(6, 1)), 18'($urandom_range(8, 1)),
                 18'($urandom_range(4, 1)), 18'($urandom_range(4, 1)),
                 18'($urandom_range(4, 1)), 18'($urandom_range(3)));
    random_phase(200);
    wait_drained();

    send_idle = 48;
    recv_idle = 29;
    write_timing(18'($urandom_range(3)), 18'($urandom_range(3)), 18'($urandom_range(3)),
                 18'($urandom_range(3)), 18'($urandom_range(3)), 18'($urandom_range(3)));
    random_phase(200);
    wait_drained();

    write_timing(18'($urandom_range(20, 1)), 18'($urandom_range(30, 1)),
                 18'($urandom_range(6, 1)), 18'($urandom_range(6, 1)),
                 18'($urandom_range(6, 1)), 18'($urandom_range(6)));
    random_phase(200);
    wait_drained();

    send_idle = 0;
    recv_idle = 0;
    write_timing(18'($urandom_range(6, 1)), 18'($urandom_range(8, 1)),
                 18'($urandom_range(4, 1)), 18'($urandom_range(4, 1)),
                 18'($urandom_range(4, 1)), 18'($urandom_range(3)));
    random_phase(200);
    wait_drained();

    // Every register at its top value: the whole reset pulse, then the
    // beginning of the conversion wait.
    write_timing(18'd1023, 18'd262143, 18'd255, 18'd255, 18'd255, 18'd255);
    push_item(KIND_START, 1'b0);
    repeat (1030) push_item(KIND_TICK, 1'($urandom_range(1)));
    wait_drained();

    repeat (5) @(posedge clk);
    if (mismatch_count == 0 && expected_readouts.size() == 0) begin
      $display("tb_single_wire_temperature_reader_core OK");
    end else begin
      $display("tb_single_wire_temperature_reader_core NOT OK");
    end
    $finish;
  end

endmodule
